// ===== rtl/crv_pkg.sv =====
// ----------------------------------------------------------------------------
// Clamped resonator voice package
// Shared types, sequencer states and fixed-point constants of the voice.
// ----------------------------------------------------------------------------
package crv_pkg;

  // Sequencer states, one-hot.
  typedef enum logic [10:0] {
    StIdle = 11'b000_0000_0001,
    StE    = 11'b000_0000_0010,
    StIdx  = 11'b000_0000_0100,
    StRom  = 11'b000_0000_1000,
    StM    = 11'b000_0001_0000,
    StV    = 11'b000_0010_0000,
    StL    = 11'b000_0100_0000,
    StScl  = 11'b000_1000_0000,
    StSw   = 11'b001_0000_0000,
    StSmp  = 11'b010_0000_0000,
    StDone = 11'b100_0000_0000
  } crv_state_e;

  // Control group from the sequencer to the datapath.
  typedef struct packed {
    crv_state_e state;
    logic       in_fire;
    logic       out_load;
  } crv_ctrl_t;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 4;
  localparam logic [CfgIdxW-1:0] CfgIdealHeight = 4'd0;
  localparam logic [CfgIdxW-1:0] CfgBaseRate    = 4'd1;
  localparam logic [CfgIdxW-1:0] CfgGain        = 4'd2;
  localparam logic [CfgIdxW-1:0] CfgLevelLimit  = 4'd3;

  // Register and state reset values.
  localparam logic [15:0] GainReset       = 16'd256;
  localparam logic [14:0] LevelLimitReset = 15'd22938;
  localparam logic [15:0] LevelReset      = 16'd11469;

  // Shared multiplier operand and product widths.
  localparam int unsigned MulW  = 33;
  localparam int unsigned ProdW = 64;

  // Fixed-point constants.
  localparam logic [12:0] Log2StepQ16 = 13'd6397;      // log2(1.07), Q0.16
  localparam logic [12:0] TenthQ16    = 13'd6554;      // 0.1, Q0.16
  localparam logic [18:0] HalfTenthQ12 = 19'd205;      // 0.05, Q4.12
  localparam logic [63:0] Ln2Q30      = 64'd744261118; // ln(2), Q2.30
  localparam logic [63:0] StepMax     = 64'd1 << 40;   // velocity step ceiling

endpackage

// ===== rtl/crv_mul.sv =====
// ----------------------------------------------------------------------------
// Clamped resonator voice shared multiplier
// One signed 33x33 multiplier with a registered 64-bit product.
// ----------------------------------------------------------------------------
module crv_mul (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic signed [crv_pkg::MulW-1:0]   op_a_i,
  input  logic signed [crv_pkg::MulW-1:0]   op_b_i,
  output logic        [crv_pkg::ProdW-1:0]  prod_o
);

  logic signed [2*crv_pkg::MulW-1:0] full;
  logic        [crv_pkg::ProdW-1:0]  prod_q;

  // Full product; every use fits in the low 64 bits.
  assign full = op_a_i * op_b_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_q <= '0;
    end else if (en_i) begin
      prod_q <= full[crv_pkg::ProdW-1:0];
    end
  end

  assign prod_o = prod_q;

endmodule

// ===== rtl/crv_exp_rom.sv =====
// ----------------------------------------------------------------------------
// Clamped resonator voice exponent table
// Constant table of 2^(i/DEPTH) in Q2.30 with a registered read port.
// ----------------------------------------------------------------------------
module crv_exp_rom #(
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  output logic [31:0]              data_o
);

  typedef logic [31:0] exp_tab_t [DEPTH];

  // Integer Taylor series of e^(x*ln2), evaluated at elaboration.
  function automatic exp_tab_t build_tab();
    exp_tab_t    tab;
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] t;
    logic [63:0] s;
    for (int i = 0; i < DEPTH; i++) begin
      x = (64'(i) << 30) / DEPTH;
      y = (x * crv_pkg::Ln2Q30) >> 30;
      s = 64'd1 << 30;
      t = 64'd1 << 30;
      t = ((t * y) >> 30) / 1;  s = s + t;
      t = ((t * y) >> 30) / 2;  s = s + t;
      t = ((t * y) >> 30) / 3;  s = s + t;
      t = ((t * y) >> 30) / 4;  s = s + t;
      t = ((t * y) >> 30) / 5;  s = s + t;
      t = ((t * y) >> 30) / 6;  s = s + t;
      t = ((t * y) >> 30) / 7;  s = s + t;
      t = ((t * y) >> 30) / 8;  s = s + t;
      t = ((t * y) >> 30) / 9;  s = s + t;
      t = ((t * y) >> 30) / 10; s = s + t;
      t = ((t * y) >> 30) / 11; s = s + t;
      t = ((t * y) >> 30) / 12; s = s + t;
      t = ((t * y) >> 30) / 13; s = s + t;
      t = ((t * y) >> 30) / 14; s = s + t;
      t = ((t * y) >> 30) / 15; s = s + t;
      t = ((t * y) >> 30) / 16; s = s + t;
      t = ((t * y) >> 30) / 17; s = s + t;
      t = ((t * y) >> 30) / 18; s = s + t;
      t = ((t * y) >> 30) / 19; s = s + t;
      t = ((t * y) >> 30) / 20; s = s + t;
      t = ((t * y) >> 30) / 21; s = s + t;
      t = ((t * y) >> 30) / 22; s = s + t;
      t = ((t * y) >> 30) / 23; s = s + t;
      tab[i] = s[31:0];
    end
    return tab;
  endfunction

  localparam exp_tab_t ExpTab = build_tab();

  logic [31:0] data_q;

  // Registered table read.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= ExpTab[addr_i];
    end
  end

  assign data_o = data_q;

endmodule

// ===== rtl/crv_seq.sv =====
// ----------------------------------------------------------------------------
// Clamped resonator voice sequencer
// Steps one sample through the shared multiplier and the update steps.
// ----------------------------------------------------------------------------
module crv_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               out_free_i,
  output crv_pkg::crv_ctrl_t ctrl_o
);

  crv_pkg::crv_state_e state_q;
  crv_pkg::crv_state_e state_d;

  // Fixed order of steps; the last one waits for a free output register.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      crv_pkg::StIdle: begin
        if (in_valid_i) state_d = crv_pkg::StE;
      end
      crv_pkg::StE:   state_d = crv_pkg::StIdx;
      crv_pkg::StIdx: state_d = crv_pkg::StRom;
      crv_pkg::StRom: state_d = crv_pkg::StM;
      crv_pkg::StM:   state_d = crv_pkg::StV;
      crv_pkg::StV:   state_d = crv_pkg::StL;
      crv_pkg::StL:   state_d = crv_pkg::StScl;
      crv_pkg::StScl: state_d = crv_pkg::StSw;
      crv_pkg::StSw:  state_d = crv_pkg::StSmp;
      crv_pkg::StSmp: state_d = crv_pkg::StDone;
      crv_pkg::StDone: begin
        if (out_free_i) state_d = crv_pkg::StIdle;
      end
      default: state_d = crv_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= crv_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign ctrl_o.state    = state_q;
  assign ctrl_o.in_fire  = (state_q == crv_pkg::StIdle) && in_valid_i;
  assign ctrl_o.out_load = (state_q == crv_pkg::StDone) && out_free_i;

  // The step after an accepted beat is always the first multiply.
  a_fire_to_e : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.in_fire |=> (state_q == crv_pkg::StE))
    else $error("accepted beat did not start the multiply sequence");

  // A result load always returns the sequencer to idle.
  a_load_to_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.out_load |=> (state_q == crv_pkg::StIdle))
    else $error("sequencer did not return to idle after a result load");

  // The scale multiply directly follows the level update.
  a_l_to_scl : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == crv_pkg::StL) |=> (state_q == crv_pkg::StScl))
    else $error("level update not followed by the scale multiply");

endmodule

// ===== rtl/clamped_resonator_voice.sv =====
// ----------------------------------------------------------------------------
// Clamped resonator voice
// Height-driven second-order oscillator producing one audio sample per tick.
// ----------------------------------------------------------------------------
// Each accepted height beat produces one sample beat. A new height is accepted
// only in idle, which the sequencer reaches again once the result is loaded
// into the output register, so one sample is finished before the next is
// taken. The pace is set by the one shared 33x33 multiplier, which is used
// seven times per sample (exponent, table index, rate product, step product,
// scale, gain, output), plus the registered exponent table read and the
// velocity and level update steps.
// The output register holds a finished sample while the next height is
// worked on; a stalled output only stalls the last step. The exponent table
// is a constant built at elaboration, so there is no clearing pass after
// reset. Configuration writes are taken in every cycle and must only be made
// while the voice is idle.
module clamped_resonator_voice #(
  parameter int unsigned EXP_TABLE_DEPTH = 256
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Configuration write channel
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [crv_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [15:0]                 cfg_data_i,
  // Height input channel
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic signed [15:0]          height_i,
  // Sample output channel
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [23:0]          sample_o
);

  localparam int unsigned AddrW = $clog2(EXP_TABLE_DEPTH);

  crv_pkg::crv_ctrl_t ctrl;

  // Configuration registers
  logic signed [15:0] ideal_q;
  logic        [15:0] base_q;
  logic        [15:0] gain_q;
  logic        [14:0] limit_q;

  // Oscillator state
  logic signed [15:0] lvl_q;
  logic signed [31:0] vel_q;
  logic        [15:0] scale_q;

  // Per-sample working registers
  logic signed [16:0] d_q;
  logic signed [5:0]  ip_q;
  logic               flip_q;

  // Output register
  logic               out_valid_q;
  logic signed [23:0] sample_q;

  // Shared multiplier and table
  logic                              mul_en;
  logic signed [crv_pkg::MulW-1:0]   mul_a;
  logic signed [crv_pkg::MulW-1:0]   mul_b;
  logic        [crv_pkg::ProdW-1:0]  prod;
  logic                              rom_en;
  logic        [31:0]                rom_data;

  // Datapath intermediates
  logic        [15:0] lvl_mag;
  logic        [5:0]  shamt;
  logic        [63:0] shifted;
  logic        [40:0] step;
  logic signed [41:0] vel_ext;
  logic signed [41:0] step_ext;
  logic signed [41:0] vel_sum;
  logic signed [31:0] vel_sat;
  logic signed [23:0] lvl_sum;
  logic signed [23:0] lim_pos;
  logic signed [23:0] lim_neg;
  logic signed [23:0] lvl_res;
  logic signed [18:0] scl_raw;
  logic        [15:0] scl_val;
  logic        [27:0] smp_mag;
  logic signed [23:0] smp_val;
  logic               out_free;

  assign out_free = !out_valid_q || out_ready_i;

  crv_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .out_free_i (out_free),
    .ctrl_o     (ctrl)
  );

  crv_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (mul_en),
    .op_a_i (mul_a),
    .op_b_i (mul_b),
    .prod_o (prod)
  );

  assign rom_en = (ctrl.state == crv_pkg::StRom);

  crv_exp_rom #(
    .DEPTH (EXP_TABLE_DEPTH)
  ) u_rom (
    .clk_i  (clk_i),
    .en_i   (rom_en),
    .addr_i (prod[24 +: AddrW]),
    .data_o (rom_data)
  );

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (ctrl.state == crv_pkg::StIdle);
  assign out_valid_o = out_valid_q;
  assign sample_o    = sample_q;

  // Magnitude of the current level.
  assign lvl_mag = lvl_q[15] ? 16'(-lvl_q) : 16'(lvl_q);

  // Multiplier operand selection per step.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (ctrl.state)
      crv_pkg::StE: begin
        mul_a = 33'(d_q);
        mul_b = 33'(crv_pkg::Log2StepQ16);
      end
      crv_pkg::StIdx: begin
        mul_a = {9'b0, prod[23:0]};
        mul_b = 33'(EXP_TABLE_DEPTH);
      end
      crv_pkg::StRom: begin
        mul_a = {17'b0, lvl_mag};
        mul_b = {17'b0, base_q};
      end
      crv_pkg::StM: begin
        mul_a = {1'b0, prod[31:0]};
        mul_b = {1'b0, rom_data};
      end
      crv_pkg::StScl: begin
        mul_a = 33'(d_q);
        mul_b = 33'(crv_pkg::TenthQ16);
      end
      crv_pkg::StSw: begin
        mul_a = {17'b0, lvl_mag};
        mul_b = {17'b0, gain_q};
      end
      crv_pkg::StSmp: begin
        mul_a = {1'b0, prod[31:0]};
        mul_b = {17'b0, scale_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_en = (ctrl.state == crv_pkg::StE)   || (ctrl.state == crv_pkg::StIdx) ||
                  (ctrl.state == crv_pkg::StRom) || (ctrl.state == crv_pkg::StM)   ||
                  (ctrl.state == crv_pkg::StScl) || (ctrl.state == crv_pkg::StSw)  ||
                  (ctrl.state == crv_pkg::StSmp);

  // Velocity step: shift the rate product by 37 minus the integer exponent.
  assign shamt    = 6'(7'd37 - {ip_q[5], ip_q});
  assign shifted  = prod >> shamt;
  assign step     = (shifted > crv_pkg::StepMax) ? crv_pkg::StepMax[40:0] : shifted[40:0];
  assign vel_ext  = 42'(vel_q);
  assign step_ext = $signed({1'b0, step});
  assign vel_sum  = lvl_q[15] ? (vel_ext + step_ext) : (vel_ext - step_ext);

  // Saturate the new velocity to 32 bits.
  always_comb begin
    if (vel_sum > 42'sd2147483647) begin
      vel_sat = 32'sh7FFF_FFFF;
    end else if (vel_sum < -42'sd2147483648) begin
      vel_sat = 32'sh8000_0000;
    end else begin
      vel_sat = vel_sum[31:0];
    end
  end

  // Level update and symmetric clamp; the velocity is floored by 2^9.
  assign lvl_sum = 24'(lvl_q) + 24'($signed(vel_q[31:9]));
  assign lim_pos = $signed({9'b0, limit_q});
  assign lim_neg = -lim_pos;

  always_comb begin
    if (lvl_sum > lim_pos) begin
      lvl_res = lim_pos;
    end else if (lvl_sum < lim_neg) begin
      lvl_res = lim_neg;
    end else begin
      lvl_res = lvl_sum;
    end
  end

  // Output scale from the registered d*0.1 product, clamped to 16 bits.
  assign scl_raw = 19'($signed(prod[29:12])) + $signed(crv_pkg::HalfTenthQ12);

  always_comb begin
    if (scl_raw < 19'sd0) begin
      scl_val = 16'd0;
    end else if (scl_raw > 19'sd65535) begin
      scl_val = 16'hFFFF;
    end else begin
      scl_val = scl_raw[15:0];
    end
  end

  // Sample: truncated magnitude, level sign, 24-bit saturation.
  assign smp_mag = prod[46:19];

  always_comb begin
    if (lvl_q[15]) begin
      if (smp_mag > 28'd8388608) begin
        smp_val = 24'sh800000;
      end else begin
        smp_val = 24'(28'd0 - smp_mag);
      end
    end else begin
      if (smp_mag > 28'd8388607) begin
        smp_val = 24'sh7FFFFF;
      end else begin
        smp_val = smp_mag[23:0];
      end
    end
  end

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ideal_q <= '0;
      base_q  <= '0;
      gain_q  <= crv_pkg::GainReset;
      limit_q <= crv_pkg::LevelLimitReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        crv_pkg::CfgIdealHeight: ideal_q <= $signed(cfg_data_i);
        crv_pkg::CfgBaseRate:    base_q  <= cfg_data_i;
        crv_pkg::CfgGain:        gain_q  <= cfg_data_i;
        crv_pkg::CfgLevelLimit:  limit_q <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  // Oscillator state updates.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvl_q   <= $signed(crv_pkg::LevelReset);
      vel_q   <= '0;
      scale_q <= '0;
      flip_q  <= 1'b0;
    end else begin
      if (ctrl.state == crv_pkg::StV) begin
        vel_q <= vel_sat;
      end
      if (ctrl.state == crv_pkg::StL) begin
        lvl_q  <= lvl_res[15:0];
        flip_q <= (lvl_q > 16'sd0) != (lvl_res > 24'sd0);
      end
      if ((ctrl.state == crv_pkg::StSw) && flip_q) begin
        scale_q <= scl_val;
      end
    end
  end

  // Per-sample working registers.
  always_ff @(posedge clk_i) begin
    if (ctrl.in_fire) begin
      d_q <= $signed({height_i[15], height_i} - {ideal_q[15], ideal_q});
    end
    if (ctrl.state == crv_pkg::StIdx) begin
      ip_q <= $signed(prod[29:24]);
    end
  end

  // Output register; a finished sample waits here for its beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.out_load) begin
      sample_q <= smp_val;
    end
  end

  // The updated level always lies within the clamp.
  a_level_clamped : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.state == crv_pkg::StL) |=>
      ((lvl_q <= $signed({1'b0, limit_q})) && (lvl_q >= -$signed({1'b0, limit_q}))))
    else $error("oscillator level outside the clamp after update");

  // The integer part of the exponent stays within the range of d.
  a_ip_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.state == crv_pkg::StIdx) |=> ((ip_q >= -6'sd25) && (ip_q <= 6'sd24)))
    else $error("exponent integer part out of range");

  // A result is never loaded over a sample that is still waiting.
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.out_load && out_valid_q) |-> out_ready_i)
    else $error("output register overwritten while its beat is pending");

endmodule
